// ----- src/dlgs_pkg.sv -----
// Shared types and constants for the depth-limited graph search block.
package dlgs_pkg;

	localparam int NODE_W  = 3;   // width of a node index and of a depth
	localparam int ROW_SH  = 3;   // log2 of the adjacency row pitch (8 bits per row)
	localparam int ADJ_W   = 64;  // adjacency register width

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_POP,
		ST_SCAN,
		ST_FINISH
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic take;   // load a new search from the input request
		logic pop;    // pop the top entry into the current-node registers
		logic push;   // discover the lowest unvisited neighbor
		logic flush;  // send the pending result out as the last one
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic start_ok;  // start node is a real node
		logic sp_empty;  // stack holds no entries
		logic expand;    // current node is below the limit and has a new neighbor
		logic out_free;  // output register can take a result this cycle
	} status_t;

endpackage

// ----- src/depth_limited_graph_search.sv -----
// Top level of the depth-limited graph search: controller plus datapath.
//
// Each accepted request starts one depth-limited depth-first search from
// start_node over the graph held in the adjacency register (bit row*8+col set
// for an edge row->col). A node is reported when it is first discovered: the
// start node at depth 0, then the unvisited neighbors of each popped node in
// ascending index order at depth+1, provided the popped node's depth is below
// depth_limit. The final result of a search carries last_node = 1. A request
// whose start_node is NODES or more is taken and produces no result. Write the
// adjacency register only while no search is running.
// A search takes the request, pops each stack entry, scans the popped node's
// row one discovery at a time and closes the row, closes the walk once the
// stack is empty, and flushes the last result; output stalls hold the scan
// and the flush. The neighbor scan steps one discovery per cycle, while the
// output is not stalled, through the single stack write port; the block
// holds one search at a time, and in_stall is high until the last result has
// entered the output register.
module depth_limited_graph_search #(
	parameter int NODES = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// configuration
	input  logic                         cfg_wr_en,
	input  logic [dlgs_pkg::ADJ_W-1:0]   cfg_wr_data,
	// request channel
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [dlgs_pkg::NODE_W-1:0]  start_node,
	input  logic [dlgs_pkg::NODE_W-1:0]  depth_limit,
	// result channel
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [dlgs_pkg::NODE_W-1:0]  found_node,
	output logic [dlgs_pkg::NODE_W-1:0]  node_depth,
	output logic                         last_node
);

	dlgs_pkg::cmd_t    cmd;
	dlgs_pkg::status_t status;
	logic              idle;

	// requests are taken only between searches
	assign in_stall = !idle;

	dlgs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.status   (status),
		.cmd      (cmd),
		.idle     (idle)
	);

	dlgs_dp #(
		.NODES (NODES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.start_node  (start_node),
		.depth_limit (depth_limit),
		.cmd         (cmd),
		.status      (status),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.found_node  (found_node),
		.node_depth  (node_depth),
		.last_node   (last_node)
	);

endmodule

// ----- src/dlgs_ctrl.sv -----
// Sequencing state machine for the depth-limited graph search.
module dlgs_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  dlgs_pkg::status_t  status,
	output dlgs_pkg::cmd_t     cmd,
	output logic               idle
);

	dlgs_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dlgs_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			dlgs_pkg::ST_IDLE: begin
				if (in_valid && status.start_ok) state_d = dlgs_pkg::ST_POP;
			end
			dlgs_pkg::ST_POP: begin
				if (status.sp_empty) state_d = dlgs_pkg::ST_FINISH;
				else state_d = dlgs_pkg::ST_SCAN;
			end
			dlgs_pkg::ST_SCAN: begin
				if (!status.expand) state_d = dlgs_pkg::ST_POP;
			end
			dlgs_pkg::ST_FINISH: begin
				if (status.out_free) state_d = dlgs_pkg::ST_IDLE;
			end
			default: state_d = dlgs_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd  = '0;
		idle = 1'b0;
		case (state_q)
			dlgs_pkg::ST_IDLE: begin
				idle     = 1'b1;
				cmd.take = in_valid && status.start_ok;
			end
			dlgs_pkg::ST_POP: begin
				cmd.pop = !status.sp_empty;
			end
			dlgs_pkg::ST_SCAN: begin
				cmd.push = status.expand && status.out_free;
			end
			dlgs_pkg::ST_FINISH: begin
				cmd.flush = status.out_free;
			end
			default: begin
				cmd  = '0;
				idle = 1'b0;
			end
		endcase
	end

endmodule

// ----- src/dlgs_dp.sv -----
// Datapath: adjacency register, visited marks, node/depth stack and result registers.
module dlgs_dp #(
	parameter int NODES = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [dlgs_pkg::ADJ_W-1:0]    cfg_wr_data,
	input  logic [dlgs_pkg::NODE_W-1:0]   start_node,
	input  logic [dlgs_pkg::NODE_W-1:0]   depth_limit,
	input  dlgs_pkg::cmd_t                cmd,
	output dlgs_pkg::status_t             status,
	input  logic                          out_stall,
	output logic                          out_valid,
	output logic [dlgs_pkg::NODE_W-1:0]   found_node,
	output logic [dlgs_pkg::NODE_W-1:0]   node_depth,
	output logic                          last_node
);

	localparam int NW    = dlgs_pkg::NODE_W;
	localparam int SP_W  = $clog2(NODES + 1);
	localparam int IDX_W = $clog2(NODES);

	logic [dlgs_pkg::ADJ_W-1:0] adj_q;
	logic [NODES-1:0]           visited_q;
	logic [NW-1:0]              node_stack_q  [NODES];
	logic [NW-1:0]              depth_stack_q [NODES];
	logic [SP_W-1:0]            sp_q;
	logic [SP_W-1:0]            sp_dec;
	logic [NW-1:0]              limit_q;
	logic [NW-1:0]              cur_node_q;
	logic [NW-1:0]              cur_depth_q;
	logic [NW-1:0]              pend_node_q;
	logic [NW-1:0]              pend_depth_q;
	logic                       out_valid_q;
	logic [NW-1:0]              out_node_q;
	logic [NW-1:0]              out_depth_q;
	logic                       out_last_q;

	logic [NODES-1:0]           row;
	logic [NODES-1:0]           cand;
	logic [NW-1:0]              low_col;
	logic [NW-1:0]              next_depth;
	logic [NODES-1:0]           start_mark;
	logic [NODES-1:0]           push_mark;
	logic                       out_load;

	assign sp_dec     = sp_q - 1'b1;
	assign row        = adj_q[{cur_node_q, {dlgs_pkg::ROW_SH{1'b0}}} +: NODES];
	assign cand       = row & ~visited_q;
	assign next_depth = cur_depth_q + 1'b1;
	assign out_load   = cmd.push || cmd.flush;

	// lowest set candidate wins
	always_comb begin
		low_col = '0;
		for (int i = NODES - 1; i >= 0; i--) begin
			if (cand[i]) low_col = NW'(i);
		end
	end

	always_comb begin
		for (int i = 0; i < NODES; i++) begin
			start_mark[i] = (start_node == NW'(i));
			push_mark[i]  = (low_col == NW'(i));
		end
	end

	assign status.start_ok = int'(start_node) < NODES;
	assign status.sp_empty = (sp_q == '0);
	assign status.expand   = (cur_depth_q < limit_q) && (cand != '0);
	assign status.out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			adj_q       <= '0;
			visited_q   <= '0;
			sp_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) adj_q <= cfg_wr_data;
			if (cmd.take) begin
				visited_q <= start_mark;
				sp_q      <= SP_W'(1);
			end else if (cmd.pop) begin
				sp_q <= sp_dec;
			end else if (cmd.push) begin
				visited_q <= visited_q | push_mark;
				sp_q      <= sp_q + 1'b1;
			end
			if (out_load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	// stack and payload registers
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			limit_q          <= depth_limit;
			node_stack_q[0]  <= start_node;
			depth_stack_q[0] <= '0;
			pend_node_q      <= start_node;
			pend_depth_q     <= '0;
		end
		if (cmd.pop) begin
			cur_node_q  <= node_stack_q[sp_dec[IDX_W-1:0]];
			cur_depth_q <= depth_stack_q[sp_dec[IDX_W-1:0]];
		end
		if (cmd.push) begin
			node_stack_q[sp_q[IDX_W-1:0]]  <= low_col;
			depth_stack_q[sp_q[IDX_W-1:0]] <= next_depth;
			pend_node_q                    <= low_col;
			pend_depth_q                   <= next_depth;
		end
		if (out_load) begin
			out_node_q  <= pend_node_q;
			out_depth_q <= pend_depth_q;
			out_last_q  <= cmd.flush;
		end
	end

	assign out_valid  = out_valid_q;
	assign found_node = out_node_q;
	assign node_depth = out_depth_q;
	assign last_node  = out_last_q;

`ifndef SYNTHESIS
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> (int'(sp_q) < NODES))
		else $error("push onto a full stack");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> (sp_q != '0))
		else $error("pop from an empty stack");
	a_take_one: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take |=> (sp_q == SP_W'(1)))
		else $error("new search does not start with one stack entry");
	a_flush_last: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.flush |=> (out_valid && last_node))
		else $error("final result not flagged last");
	a_push_new: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> ((visited_q & push_mark) == '0))
		else $error("visited node discovered again");
`endif

endmodule

// ----- sim/depth_limited_graph_search_tb.sv -----
// Self-checking testbench for the depth-limited graph search block.
`timescale 1ns / 1ps

module depth_limited_graph_search_tb;

	localparam int NW           = dlgs_pkg::NODE_W;
	localparam int AW           = dlgs_pkg::ADJ_W;
	localparam int TB_NODES     = 8;
	localparam int CLK_PERIOD   = 4;
	localparam int RESET_CYCLES = 10;
	// Settle time after a drain; covers a full eight-node walk with margin.
	localparam int SETTLE_CYCLES = 40;
	localparam int LONG_HOLD     = 300;
	localparam int ITEMS_PER_SET = 17;
	localparam longint unsigned RUN_LIMIT_NS = 2000000;

	// one search request
	typedef struct packed {
		logic [NW-1:0] start;
		logic [NW-1:0] limit;
	} search_req_t;

	// one discovered node as the block should report it
	typedef struct packed {
		logic [NW-1:0] node;
		logic [NW-1:0] depth;
		logic          last;
	} find_t;

	logic          clk         = 1'b0;
	logic          arst_n      = 1'b0;
	logic          cfg_wr_en   = 1'b0;
	logic [AW-1:0] cfg_wr_data = '0;
	logic          in_valid    = 1'b0;
	logic          in_stall;
	logic [NW-1:0] start_node  = '0;
	logic [NW-1:0] depth_limit = '0;
	logic          out_valid;
	logic          out_stall   = 1'b0;
	logic [NW-1:0] found_node;
	logic [NW-1:0] node_depth;
	logic          last_node;

	// testbench copy of the adjacency register
	logic [AW-1:0] graph_bits = '0;

	search_req_t   search_queue[$];   // requests not yet offered
	find_t         expected_finds[$]; // discoveries still owed by the block

	int            send_idle_pct = 8;
	int            recv_idle_pct = 53;
	int            mismatch_count = 0;

	// long receiver hold-off, armed once by the stimulus
	logic          hold_go   = 1'b0;
	logic          hold_done = 1'b0;
	int            stall_left = 0;

	depth_limited_graph_search #(
		.NODES(TB_NODES)
	) uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.start_node (start_node),
		.depth_limit(depth_limit),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.found_node (found_node),
		.node_depth (node_depth),
		.last_node  (last_node)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Walk the graph the way the block should: stack of (node, depth) pairs,
	// mark and report on push, expand a popped node only below the limit,
	// neighbors in ascending order. Appends the discoveries to the store.
	function automatic void walk_graph(input logic [NW-1:0] root, input logic [NW-1:0] limit);
		logic [7:0]    seen;
		logic [NW-1:0] node_stk[8];
		logic [NW-1:0] depth_stk[8];
		find_t         finds[8];
		int            sp;
		int            count;
		logic [NW-1:0] cur;
		logic [NW-1:0] cur_depth;
		if (int'(root) >= TB_NODES)
			return;  // not a real node: taken, nothing reported
		seen       = '0;
		seen[root] = 1'b1;
		finds[0]   = '{node: root, depth: '0, last: 1'b0};
		count      = 1;
		node_stk[0]  = root;
		depth_stk[0] = '0;
		sp = 1;
		while (sp > 0) begin
			sp--;
			cur       = node_stk[sp];
			cur_depth = depth_stk[sp];
			if (cur_depth < limit) begin
				for (int col = 0; col < TB_NODES; col++) begin
					// self loops and edges back to visited nodes fall out here
					if (graph_bits[int'(cur) * 8 + col] && !seen[col] && sp < 8 && count < 8) begin
						seen[col]      = 1'b1;
						finds[count]   = '{node: NW'(col), depth: cur_depth + 1'b1, last: 1'b0};
						count++;
						node_stk[sp]   = NW'(col);
						depth_stk[sp]  = cur_depth + 1'b1;
						sp++;
					end
				end
			end
		end
		for (int i = 0; i < count; i++) begin
			finds[i].last = (i == count - 1);
			expected_finds.push_back(finds[i]);
		end
	endfunction

	// Request driver: holds a stalled request steady, otherwise offers the
	// next queued one unless it idles this cycle. Predicts on acceptance.
	always @(posedge clk or negedge arst_n) begin : req_driver
		search_req_t req;
		if (!arst_n) begin
			in_valid    <= 1'b0;
			start_node  <= '0;
			depth_limit <= '0;
		end else begin
			if (in_valid && !in_stall)
				walk_graph(start_node, depth_limit);
			if (!in_valid || !in_stall) begin
				if (search_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					req = search_queue.pop_front();
					in_valid    <= 1'b1;
					start_node  <= req.start;
					depth_limit <= req.limit;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Hold-off counter for the result side; runs once when armed.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stall_left <= 0;
			hold_done  <= 1'b0;
		end else if (hold_go && !hold_done) begin
			stall_left <= LONG_HOLD;
			hold_done  <= 1'b1;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
		end
	end

	// Result monitor: every accepted result against the oldest expectation.
	always @(posedge clk or negedge arst_n) begin : find_monitor
		find_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_finds.size() == 0) begin
					$error("result with nothing expected: found_node %0d node_depth %0d last_node %0d",
						found_node, node_depth, last_node);
					mismatch_count <= mismatch_count + 1;
				end else begin
					want = expected_finds.pop_front();
					if (found_node !== want.node || node_depth !== want.depth
							|| last_node !== want.last)
						mismatch_count <= mismatch_count + 1;
					if (found_node !== want.node)
						$error("found_node: expected %0d, got %0d", want.node, found_node);
					if (node_depth !== want.depth)
						$error("node_depth: expected %0d, got %0d", want.depth, node_depth);
					if (last_node !== want.last)
						$error("last_node: expected %0d, got %0d", want.last, last_node);
				end
			end
			out_stall <= (stall_left != 0) || ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	task automatic queue_search(input int start, input int limit);
		search_queue.push_back('{start: NW'(start), limit: NW'(limit)});
	endtask

	// Sender side waits until every request is out and every result is back,
	// then gives the block time to close its walk.
	task automatic drain();
		while (!(search_queue.size() == 0 && !in_valid && expected_finds.size() == 0))
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Adjacency write; only called with the block idle.
	task automatic write_graph(input logic [AW-1:0] value);
		@(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		graph_bits  <= value;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		cfg_wr_data <= ~value;  // junk on the bus while disabled
	endtask

	task automatic queue_random(input int n);
		for (int i = 0; i < n; i++) begin
			// mostly deep limits so the walk gets past the first level
			if ($urandom_range(0, 3) == 0)
				queue_search($urandom_range(0, 7), $urandom_range(0, 2));
			else
				queue_search($urandom_range(0, 7), $urandom_range(3, 7));
		end
	endtask

	// random graph of the given flavor
	function automatic logic [AW-1:0] pick_graph(input int kind, input int mode);
		logic [AW-1:0] g;
		int            order[8];
		int            j;
		int            t;
		case (kind)
			0: begin
				g = {$urandom, $urandom};
			end
			1: begin
				g = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
			end
			2: begin
				// shuffled path through every node plus a few stray edges
				for (int i = 0; i < 8; i++)
					order[i] = i;
				for (int i = 7; i > 0; i--) begin
					j = $urandom_range(0, i);
					t = order[i];
					order[i] = order[j];
					order[j] = t;
				end
				g = {$urandom, $urandom} & {$urandom, $urandom}
					& {$urandom, $urandom} & {$urandom, $urandom};
				for (int i = 0; i < 7; i++)
					g[order[i] * 8 + order[i + 1]] = 1'b1;
			end
			default: begin
				g = (mode == 1) ? '0 : '1;
			end
		endcase
		return g;
	endfunction

	initial begin : stimulus
		logic [AW-1:0] g;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. Empty graph: only the root ever shows up.
		write_graph('0);
		queue_search(0, 0);
		queue_search(7, 7);
		queue_search(5, 3);
		drain();

		// Complete graph with self loops; a zero limit still gives the root.
		write_graph('1);
		queue_search(0, 7);
		queue_search(7, 0);
		queue_search(3, 1);
		queue_search(4, 7);
		drain();

		// Chain 0..7 with self loops and back edges: deepest depths reachable.
		g = '0;
		for (int i = 0; i < 8; i++) begin
			g[i * 8 + i] = 1'b1;
			if (i < 7) begin
				g[i * 8 + i + 1]   = 1'b1;
				g[(i + 1) * 8 + i] = 1'b1;
			end
		end
		write_graph(g);
		queue_search(0, 7);
		queue_search(0, 3);
		queue_search(7, 7);
		queue_search(3, 2);
		drain();

		// Binary tree rooted at 0.
		g = '0;
		g[0 * 8 + 1] = 1'b1;
		g[0 * 8 + 2] = 1'b1;
		g[1 * 8 + 3] = 1'b1;
		g[1 * 8 + 4] = 1'b1;
		g[2 * 8 + 5] = 1'b1;
		g[2 * 8 + 6] = 1'b1;
		g[3 * 8 + 7] = 1'b1;
		write_graph(g);
		queue_search(0, 7);
		queue_search(0, 1);
		queue_search(0, 2);
		queue_search(2, 7);
		drain();

		// Alternating bit patterns.
		write_graph({16{4'h5}});
		queue_search(1, 7);
		queue_search(6, 7);
		drain();
		write_graph({16{4'hA}});
		queue_search(1, 7);
		queue_search(6, 7);
		drain();

		// Random part: three idling modes, four graph flavors each.
		for (int mode = 0; mode < 3; mode++) begin
			case (mode)
				0: begin
					send_idle_pct <= 8;
					recv_idle_pct <= 53;
				end
				1: begin
					send_idle_pct <= 53;
					recv_idle_pct <= 8;
				end
				default: begin
					send_idle_pct <= 0;
					recv_idle_pct <= 0;
				end
			endcase
			for (int kind = 0; kind < 4; kind++) begin
				write_graph(pick_graph(kind, mode));
				queue_random(8);
				if (kind == 1)
					drain();  // sender pauses until the block has caught up
				queue_random(ITEMS_PER_SET - 8);
				// result side holds off while requests keep coming
				if (mode == 2 && kind == 0)
					hold_go <= 1'b1;
				drain();
			end
		end

		if (mismatch_count == 0 && expected_finds.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	initial begin : watchdog
		#(RUN_LIMIT_NS);
		$display("Test completed with failures");
		$finish;
	end

endmodule
